[hdl/imf_pkg.sv]
// Package for the image median filter: widths, register and opcode codes,
// controller state type and the command and status structs.
// No dependencies.
`default_nettype none
package imf_pkg;
	localparam int PIX_W      = 8;
	localparam int CNT_W      = 26;
	localparam int COL_W      = 11;
	localparam int ROW_W      = 16;
	localparam int RAD_W      = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd2;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SETUP,
		ST_READ,
		ST_DRAIN,
		ST_SHIFT,
		ST_OUT
	} imf_state_t;

	typedef struct packed {
		logic accept;
		logic setup;
		logic base;
		logic read;
		logic drain;
		logic shift;
		logic done;
	} imf_cmd_t;

	typedef struct packed {
		logic busy;
		logic due;
		logic last_read;
		logic shift_zero;
	} imf_status_t;
endpackage
`default_nettype wire

[hdl/imf_in_if.sv]
// Input channel of the image median filter: valid/ready handshake with
// opcode and pixel payload. Depends on imf_pkg.
`default_nettype none
interface imf_in_if;
	logic                         valid;
	logic                         ready;
	logic                         opcode;
	logic [imf_pkg::PIX_W-1:0]    pixel_value;
	modport source (output valid, output opcode, output pixel_value, input ready);
	modport sink (input valid, input opcode, input pixel_value, output ready);
endinterface
`default_nettype wire

[hdl/imf_out_if.sv]
// Output channel of the image median filter: valid/ready handshake with
// filtered pixel and end-of-frame flag. Depends on imf_pkg.
`default_nettype none
interface imf_out_if;
	logic                         valid;
	logic                         ready;
	logic [imf_pkg::PIX_W-1:0]    filtered_pixel;
	logic                         frame_last;
	modport source (output valid, output filtered_pixel, output frame_last, input ready);
	modport sink (input valid, input filtered_pixel, input frame_last, output ready);
endinterface
`default_nettype wire

[hdl/image_median_filter_core.sv]
// Image median filter over a raster stream of 8-bit grayscale pixels.
// Depends on imf_pkg, imf_in_if, imf_out_if, imf_ctrl and imf_datapath.
//
// The input channel carries one beat per item: a pixel or a flush tick.
// The output channel carries one beat per result: the median of the clipped
// square window of side 2r+1 and a flag on the last pixel of the frame.
// Results trail the pixels by r*width+r positions; flush ticks drain the
// remaining results after the frame has fully arrived, one per tick.
// The configuration port writes width, height and radius; any write starts
// a new frame and blocks intake in the cycle after it.
// An item that causes no result only goes through a check whether one is
// due. An item that causes a result goes through setup, window reading,
// draining and shifting before its beat is offered: the window is read
// one pixel per cycle from the history memory and inserted into a sorting
// row, then shifted to the median rank. The block holds one item at a time;
// while the receiver stalls the result beat stays valid and no input is taken.
// Reset clears the counters and loads width 1, height 1, radius 1.
// The history memory needs no clearing pass.
`default_nettype none
module image_median_filter_core #(
	parameter int MAX_WIDTH     = 1024,
	parameter int MAX_RADIUS    = 3,
	parameter int HISTORY_DEPTH = 8192
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [imf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [imf_pkg::CFG_DATA_W-1:0] cfg_wdata,
	imf_in_if.sink                              in_ch,
	imf_out_if.source                           out_ch
);
	import imf_pkg::*;

	imf_cmd_t    cmd;
	imf_status_t status;
	logic        in_ready;
	logic        out_valid;
	logic [PIX_W-1:0] res_pixel;
	logic        res_last;

	imf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ch.ready),
		.status   (status),
		.cmd      (cmd)
	);

	imf_datapath #(
		.MAX_WIDTH    (MAX_WIDTH),
		.MAX_RADIUS   (MAX_RADIUS),
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_opcode(in_ch.opcode),
		.in_pixel (in_ch.pixel_value),
		.cmd      (cmd),
		.status   (status),
		.res_pixel(res_pixel),
		.res_last (res_last)
	);

	assign in_ch.ready           = in_ready;
	assign out_ch.valid          = out_valid;
	assign out_ch.filtered_pixel = res_pixel;
	assign out_ch.frame_last     = res_last;
endmodule
`default_nettype wire

[hdl/imf_sorter.sv]
// Insertion sorter: a row of compare-and-shift cells kept in ascending order,
// with a shift-down to bring the wanted rank to the head. Depends on imf_pkg.
`default_nettype none
module imf_sorter #(
	parameter int DEPTH = 49
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      clear,
	input  wire logic                      insert,
	input  wire logic [imf_pkg::PIX_W-1:0] ins_val,
	input  wire logic                      shift,
	output logic [imf_pkg::PIX_W-1:0]      head
);
	import imf_pkg::*;

	logic [PIX_W-1:0] val_q [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [DEPTH-1:0] gt;

	always_comb begin
		for (int k = 0; k < DEPTH; k++) begin
			gt[k] = !vld_q[k] || (val_q[k] > ins_val);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (clear) begin
			vld_q <= '0;
		end else if (insert) begin
			for (int k = 0; k < DEPTH; k++) begin
				if (k > 0 && gt[k-1]) begin
					vld_q[k] <= vld_q[k-1];
				end else if (gt[k]) begin
					vld_q[k] <= 1'b1;
				end
			end
		end else if (shift) begin
			vld_q <= {1'b0, vld_q[DEPTH-1:1]};
		end
	end

	always_ff @(posedge clk) begin
		if (insert) begin
			for (int k = 0; k < DEPTH; k++) begin
				if (k > 0 && gt[k-1]) begin
					val_q[k] <= val_q[k-1];
				end else if (gt[k]) begin
					val_q[k] <= ins_val;
				end
			end
		end else if (shift) begin
			for (int k = 0; k < DEPTH - 1; k++) begin
				val_q[k] <= val_q[k+1];
			end
		end
	end

	assign head = val_q[0];
endmodule
`default_nettype wire

[hdl/imf_datapath.sv]
// Datapath: configuration registers, frame counters, pixel history memory,
// window address generation and the sorter. Depends on imf_pkg, imf_sorter.
`default_nettype none
module imf_datapath #(
	parameter int MAX_WIDTH     = 1024,
	parameter int MAX_RADIUS    = 3,
	parameter int HISTORY_DEPTH = 8192
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [imf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [imf_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                           in_opcode,
	input  wire logic [imf_pkg::PIX_W-1:0]      in_pixel,
	input  wire imf_pkg::imf_cmd_t              cmd,
	output imf_pkg::imf_status_t                status,
	output logic [imf_pkg::PIX_W-1:0]           res_pixel,
	output logic                                res_last
);
	import imf_pkg::*;

	localparam int AW      = $clog2(HISTORY_DEPTH);
	localparam int WIN_MAX = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
	localparam int NW      = $clog2(WIN_MAX + 1);

	logic [COL_W-1:0] cfg_width_q;
	logic [ROW_W-1:0] cfg_height_q;
	logic [RAD_W-1:0] cfg_radius_q;
	logic             busy_q;

	logic [COL_W-1:0] w_eff;
	logic [ROW_W-1:0] h_eff;
	logic [RAD_W-1:0] r_eff;
	logic [CNT_W-1:0] total_q;
	logic [CNT_W:0]   delay_q;

	logic [CNT_W-1:0] recv_q;
	logic [CNT_W-1:0] sent_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;

	logic [ROW_W-1:0] y0_q, y1_q, y_q;
	logic [COL_W-1:0] x0_q, x1_q, x_q;
	logic [CNT_W-1:0] pos_q, rowbase_q;
	logic [NW-1:0]    cnt_q, shl_q;

	logic [PIX_W-1:0] mem [HISTORY_DEPTH];
	logic [PIX_W-1:0] mem_rd_q;
	logic             rd_s1;

	logic             wr_ok;
	logic             frame_end;
	logic [ROW_W-1:0] y0_c, y1_c;
	logic [COL_W-1:0] x0_c, x1_c;
	logic [ROW_W:0]   ysum;
	logic [COL_W:0]   xsum;
	logic [CNT_W:0]   base_prod;

	always_comb begin
		if (cfg_width_q == '0) begin
			w_eff = COL_W'(1);
		end else if (32'(cfg_width_q) > MAX_WIDTH) begin
			w_eff = COL_W'(MAX_WIDTH);
		end else begin
			w_eff = cfg_width_q;
		end
		h_eff = (cfg_height_q == '0) ? ROW_W'(1) : cfg_height_q;
		r_eff = (32'(cfg_radius_q) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : cfg_radius_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_width_q  <= COL_W'(1);
			cfg_height_q <= ROW_W'(1);
			cfg_radius_q <= RAD_W'(1);
			busy_q       <= 1'b0;
		end else begin
			busy_q <= cfg_we;
			if (cfg_we) begin
				case (cfg_index)
					REG_WIDTH:  cfg_width_q  <= cfg_wdata[COL_W-1:0];
					REG_HEIGHT: cfg_height_q <= cfg_wdata[ROW_W-1:0];
					REG_RADIUS: cfg_radius_q <= cfg_wdata[RAD_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		total_q <= CNT_W'(w_eff) * CNT_W'(h_eff);
		delay_q <= (CNT_W+1)'(r_eff) * (CNT_W+1)'(w_eff) + (CNT_W+1)'(r_eff);
	end

	assign wr_ok     = (in_opcode == OP_PIXEL) && (recv_q < total_q);
	assign frame_end = ({1'b0, sent_q} + (CNT_W+1)'(1)) == {1'b0, total_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recv_q <= '0;
			sent_q <= '0;
			row_q  <= '0;
			col_q  <= '0;
		end else if (cfg_we) begin
			recv_q <= '0;
			sent_q <= '0;
			row_q  <= '0;
			col_q  <= '0;
		end else begin
			if (cmd.accept && wr_ok) begin
				recv_q <= recv_q + CNT_W'(1);
			end
			if (cmd.done) begin
				if (frame_end) begin
					recv_q <= '0;
					sent_q <= '0;
					row_q  <= '0;
					col_q  <= '0;
				end else begin
					sent_q <= sent_q + CNT_W'(1);
					if (col_q == w_eff - COL_W'(1)) begin
						col_q <= '0;
						row_q <= row_q + ROW_W'(1);
					end else begin
						col_q <= col_q + COL_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && wr_ok) begin
			mem[recv_q[AW-1:0]] <= in_pixel;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.read) begin
			mem_rd_q <= mem[pos_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
		end else begin
			rd_s1 <= cmd.read;
		end
	end

	always_comb begin
		y0_c = (row_q > ROW_W'(r_eff)) ? row_q - ROW_W'(r_eff) : '0;
		ysum = {1'b0, row_q} + (ROW_W+1)'(r_eff);
		y1_c = (ysum < {1'b0, h_eff}) ? ysum[ROW_W-1:0] : h_eff - ROW_W'(1);
		x0_c = (col_q > COL_W'(r_eff)) ? col_q - COL_W'(r_eff) : '0;
		xsum = {1'b0, col_q} + (COL_W+1)'(r_eff);
		x1_c = (xsum < {1'b0, w_eff}) ? xsum[COL_W-1:0] : w_eff - COL_W'(1);
		base_prod = (CNT_W+1)'(y0_q) * (CNT_W+1)'(w_eff) + (CNT_W+1)'(x0_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			y0_q  <= y0_c;
			y1_q  <= y1_c;
			x0_q  <= x0_c;
			x1_q  <= x1_c;
			cnt_q <= '0;
		end
		if (cmd.base) begin
			pos_q     <= base_prod[CNT_W-1:0];
			rowbase_q <= base_prod[CNT_W-1:0];
			y_q       <= y0_q;
			x_q       <= x0_q;
		end
		if (cmd.read) begin
			cnt_q <= cnt_q + NW'(1);
			if (x_q == x1_q) begin
				x_q       <= x0_q;
				y_q       <= y_q + ROW_W'(1);
				rowbase_q <= rowbase_q + CNT_W'(w_eff);
				pos_q     <= rowbase_q + CNT_W'(w_eff);
			end else begin
				x_q   <= x_q + COL_W'(1);
				pos_q <= pos_q + CNT_W'(1);
			end
		end
		if (cmd.drain) begin
			shl_q <= cnt_q >> 1;
		end
		if (cmd.shift) begin
			shl_q <= shl_q - NW'(1);
		end
	end

	imf_sorter #(
		.DEPTH(WIN_MAX)
	) u_sorter (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (cmd.setup),
		.insert (rd_s1),
		.ins_val(mem_rd_q),
		.shift  (cmd.shift),
		.head   (res_pixel)
	);

	always_comb begin
		status.busy       = busy_q;
		status.due        = (sent_q < total_q) &&
			((recv_q == total_q) || ({1'b0, recv_q} > {1'b0, sent_q} + delay_q));
		status.last_read  = (x_q == x1_q) && (y_q == y1_q);
		status.shift_zero = (shl_q == '0);
	end

	assign res_last = frame_end;
endmodule
`default_nettype wire

[hdl/imf_ctrl.sv]
// Controller state machine: sequences item intake, window gathering, rank
// selection and result delivery. Depends on imf_pkg.
`default_nettype none
module imf_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	input  wire imf_pkg::imf_status_t status,
	output imf_pkg::imf_cmd_t         cmd
);
	import imf_pkg::*;

	imf_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid && !status.busy) state_nxt = ST_CHECK;
			ST_CHECK: state_nxt = status.due ? ST_SETUP : ST_IDLE;
			ST_SETUP: state_nxt = ST_READ;
			ST_READ:  if (status.last_read) state_nxt = ST_DRAIN;
			ST_DRAIN: state_nxt = ST_SHIFT;
			ST_SHIFT: if (status.shift_zero) state_nxt = ST_OUT;
			ST_OUT:   if (out_ready) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = !status.busy;
				cmd.accept = in_valid && !status.busy;
			end
			ST_CHECK: cmd.setup = status.due;
			ST_SETUP: cmd.base = 1'b1;
			ST_READ:  cmd.read = 1'b1;
			ST_DRAIN: cmd.drain = 1'b1;
			ST_SHIFT: cmd.shift = !status.shift_zero;
			ST_OUT: begin
				out_valid = 1'b1;
				cmd.done  = out_ready;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire
